// ----- hdl/assert_macros.svh -----
// Assertion macros shared by the RTL of the byte-stuffed frame receiver.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that holds on every clock edge outside reset.
`define ASSERT_CLK(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("assertion failed");

// Condition that must never be seen outside reset.
`define ASSERT_NEVER(label, clk, rstn, cond) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) \
        else $error("forbidden condition seen");

`endif

// ----- hdl/bsfr_pkg.sv -----
// Package for the byte-stuffed frame receiver: types, register codes and constants.
// No dependencies.
package bsfr_pkg;

    localparam int BYTE_W      = 8;
    localparam int CFG_INDEX_W = 2;
    localparam int POS_W       = 9;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_FLAG_BYTE   = 2'd0,
        CFG_ESCAPE_BYTE = 2'd1,
        CFG_ESCAPE_MASK = 2'd2
    } cfg_index_t;

    localparam logic [BYTE_W-1:0] FLAG_BYTE_RESET   = 8'h7e;
    localparam logic [BYTE_W-1:0] ESCAPE_BYTE_RESET = 8'h7d;
    localparam logic [BYTE_W-1:0] ESCAPE_MASK_RESET = 8'h20;

    // Frame position: idle, expecting length, then body byte p-2.
    localparam logic [POS_W-1:0] POS_IDLE   = 9'd0;
    localparam logic [POS_W-1:0] POS_LENGTH = 9'd1;
    localparam logic [POS_W-1:0] POS_BODY   = 9'd2;

    typedef struct packed {
        logic [BYTE_W-1:0] flag_byte;
        logic [BYTE_W-1:0] escape_byte;
        logic [BYTE_W-1:0] escape_mask;
    } cfg_t;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              is_command;
        logic              is_last;
        logic              frame_aborted;
        logic              empty_frame;
    } result_t;

endpackage

// ----- hdl/bsfr_if.sv -----
// Handshake interfaces for the receive, result and configuration channels.
// Depends on bsfr_pkg for widths.
interface bsfr_rx_if;
    logic                           valid;
    logic                           ready;
    logic [bsfr_pkg::BYTE_W-1:0]    rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface bsfr_res_if;
    logic                           valid;
    logic                           ready;
    logic [bsfr_pkg::BYTE_W-1:0]    data_byte;
    logic                           is_command;
    logic                           is_last;
    logic                           frame_aborted;
    logic                           empty_frame;

    modport source (output valid, output data_byte, output is_command, output is_last,
                    output frame_aborted, output empty_frame, input ready);
    modport sink   (input valid, input data_byte, input is_command, input is_last,
                    input frame_aborted, input empty_frame, output ready);
endinterface

interface bsfr_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [bsfr_pkg::CFG_INDEX_W-1:0]   index;
    logic [bsfr_pkg::BYTE_W-1:0]        data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- hdl/byte_stuffed_frame_receiver.sv -----
// Byte-stuffed frame receiver: input register, deframing logic, result register.
// A byte accepted into the input register is deframed and its result held in the result register.
// Throughput: one byte per cycle while results are taken; an empty input register still fills while a result waits.
// Reset clears frame state and loads flag 0x7e, escape 0x7d, mask 0x20.
// Depends on bsfr_pkg, bsfr_if, bsfr_cfg_regs, bsfr_core and assert_macros.svh.
`include "assert_macros.svh"

module byte_stuffed_frame_receiver (
    input  logic              clk,
    input  logic              rst_n,
    bsfr_rx_if.sink           rx,
    bsfr_res_if.source        result,
    bsfr_cfg_if.sink          cfg
);

    logic                        in_valid_reg;
    logic [bsfr_pkg::BYTE_W-1:0] in_byte_reg;
    logic                        out_valid_reg;
    bsfr_pkg::result_t           out_reg;
    logic                        stall;
    logic                        rx_accept;
    logic                        core_valid;
    bsfr_pkg::result_t           core_res;
    bsfr_pkg::cfg_t              cfg_now;

    assign stall     = out_valid_reg && !result.ready;
    assign rx.ready  = !in_valid_reg || !stall;
    assign rx_accept = rx.valid && rx.ready;
    assign cfg.ready = 1'b1;

    bsfr_cfg_regs u_cfg_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg.valid && cfg.ready),
        .wr_index (cfg.index),
        .wr_data  (cfg.data),
        .cfg      (cfg_now)
    );

    bsfr_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .byte_en   (in_valid_reg && !stall),
        .rx_byte   (in_byte_reg),
        .cfg       (cfg_now),
        .res_valid (core_valid),
        .res       (core_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (rx_accept)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (!stall)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx_accept)
        begin
            in_byte_reg <= rx.rx_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (!stall)
        begin
            out_valid_reg <= core_valid;
        end
    end

    // hold the result until the transaction completes
    always_ff @(posedge clk)
    begin
        if (!stall)
        begin
            out_reg <= core_res;
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.data_byte     = out_reg.data_byte;
    assign result.is_command    = out_reg.is_command;
    assign result.is_last       = out_reg.is_last;
    assign result.frame_aborted = out_reg.frame_aborted;
    assign result.empty_frame   = out_reg.empty_frame;

    `ASSERT_CLK(a_in_held_on_stall, clk, rst_n,
        (in_valid_reg && stall) |=> (in_valid_reg && $stable(in_byte_reg)))
    `ASSERT_CLK(a_status_exclusive, clk, rst_n,
        out_valid_reg |-> $onehot0({out_reg.frame_aborted, out_reg.empty_frame,
                                    out_reg.is_command}))
    `ASSERT_CLK(a_empty_is_last, clk, rst_n,
        (out_valid_reg && out_reg.empty_frame) |-> (out_reg.is_last && out_reg.data_byte == '0))
    `ASSERT_NEVER(a_abort_clean, clk, rst_n,
        out_valid_reg && out_reg.frame_aborted && (out_reg.is_last || out_reg.data_byte != '0))

endmodule

// ----- hdl/bsfr_cfg_regs.sv -----
// Configuration registers: flag byte, escape byte and escape mask.
// Depends on bsfr_pkg.
module bsfr_cfg_regs (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               wr_en,
    input  logic [bsfr_pkg::CFG_INDEX_W-1:0]   wr_index,
    input  logic [bsfr_pkg::BYTE_W-1:0]        wr_data,
    output bsfr_pkg::cfg_t                     cfg
);

    bsfr_pkg::cfg_t cfg_reg;
    bsfr_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (bsfr_pkg::cfg_index_t'(wr_index))
                bsfr_pkg::CFG_FLAG_BYTE:   cfg_next.flag_byte   = wr_data;
                bsfr_pkg::CFG_ESCAPE_BYTE: cfg_next.escape_byte = wr_data;
                bsfr_pkg::CFG_ESCAPE_MASK: cfg_next.escape_mask = wr_data;
                default:                   cfg_next = cfg_reg;   // drop unknown index
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.flag_byte   <= bsfr_pkg::FLAG_BYTE_RESET;
            cfg_reg.escape_byte <= bsfr_pkg::ESCAPE_BYTE_RESET;
            cfg_reg.escape_mask <= bsfr_pkg::ESCAPE_MASK_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- hdl/bsfr_core.sv -----
// Deframing logic: frame position, length and escape state, one byte per cycle while byte_en is high.
// Depends on bsfr_pkg.
module bsfr_core (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           byte_en,
    input  logic [bsfr_pkg::BYTE_W-1:0]    rx_byte,
    input  bsfr_pkg::cfg_t                 cfg,
    output logic                           res_valid,
    output bsfr_pkg::result_t              res
);

    logic [bsfr_pkg::POS_W-1:0]  pos_reg;
    logic [bsfr_pkg::POS_W-1:0]  pos_next;
    logic [bsfr_pkg::BYTE_W-1:0] len_reg;
    logic [bsfr_pkg::BYTE_W-1:0] len_next;
    logic                        esc_reg;
    logic                        esc_next;
    logic [bsfr_pkg::BYTE_W-1:0] unescaped;
    logic                        last_body;

    assign unescaped = esc_reg ? (rx_byte ^ cfg.escape_mask) : rx_byte;
    assign last_body = (pos_reg >= ({1'b0, len_reg} + 9'd1));

    always_comb
    begin
        pos_next  = pos_reg;
        len_next  = len_reg;
        esc_next  = esc_reg;
        res_valid = 1'b0;
        res       = '0;
        if (byte_en)
        begin
            if (rx_byte == cfg.flag_byte)
            begin
                // a flag always restarts; report the frame it cut short
                pos_next = bsfr_pkg::POS_LENGTH;
                len_next = '0;
                esc_next = 1'b0;
                if (pos_reg != bsfr_pkg::POS_IDLE)
                begin
                    res_valid         = 1'b1;
                    res.frame_aborted = 1'b1;
                end
            end
            else if (pos_reg == bsfr_pkg::POS_IDLE)
            begin
                pos_next = pos_reg;   // hunt for a flag
            end
            else if (rx_byte == cfg.escape_byte)
            begin
                esc_next = 1'b1;
            end
            else
            begin
                esc_next = 1'b0;
                if (pos_reg == bsfr_pkg::POS_LENGTH)
                begin
                    len_next = unescaped;
                    if (unescaped == '0)
                    begin
                        pos_next        = bsfr_pkg::POS_IDLE;
                        res_valid       = 1'b1;
                        res.is_last     = 1'b1;
                        res.empty_frame = 1'b1;
                    end
                    else
                    begin
                        pos_next = bsfr_pkg::POS_BODY;
                    end
                end
                else
                begin
                    res_valid      = 1'b1;
                    res.data_byte  = unescaped;
                    res.is_command = (pos_reg == bsfr_pkg::POS_BODY);
                    res.is_last    = last_body;
                    if (last_body)
                    begin
                        pos_next = bsfr_pkg::POS_IDLE;
                        len_next = '0;
                    end
                    else
                    begin
                        pos_next = pos_reg + 9'd1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= bsfr_pkg::POS_IDLE;
            len_reg <= '0;
            esc_reg <= 1'b0;
        end
        else
        begin
            pos_reg <= pos_next;
            len_reg <= len_next;
            esc_reg <= esc_next;
        end
    end

endmodule
